### rtl/hsv2rgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
`default_nettype none

package hsv2rgb_pkg;

  localparam int HueBits            = 9;
  localparam int FracBits           = 6;
  localparam int HueSector          = 60;
  localparam int HueTurn            = 360;
  localparam int ChannelBitsDefault = 8;

  typedef enum logic [2:0] {
    SECTOR_RED_YELLOW    = 3'd0,
    SECTOR_YELLOW_GREEN  = 3'd1,
    SECTOR_GREEN_CYAN    = 3'd2,
    SECTOR_CYAN_BLUE     = 3'd3,
    SECTOR_BLUE_MAGENTA  = 3'd4,
    SECTOR_MAGENTA_RED   = 3'd5
  } sector_e;

endpackage

`default_nettype wire

### rtl/hsv_to_rgb_converter.sv
// Pipelined HSV to RGB color converter with stream handshakes on both sides.
// Throughput: one item per cycle while the output is not stalled; the nine register
// stages and their valid bits advance independently, so a stalled output only holds
// the stages it blocks.
// Reset clears the valid bits only; the data registers are not reset.
`default_nettype none

module hsv_to_rgb_converter #(
  parameter int CHANNEL_BITS = hsv2rgb_pkg::ChannelBitsDefault
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      s_axis_tvalid,
  output logic                                           s_axis_tready,
  // Fields from bit 0 up: hue, saturation, brightness.
  input  wire logic [((hsv2rgb_pkg::HueBits + 2 * CHANNEL_BITS + 7) / 8) * 8 - 1:0]
                                                         s_axis_tdata,
  output logic                                           m_axis_tvalid,
  input  wire logic                                      m_axis_tready,
  // Fields from bit 0 up: red, green, blue.
  output logic [((3 * CHANNEL_BITS + 7) / 8) * 8 - 1:0]  m_axis_tdata
);

  localparam int C      = CHANNEL_BITS;
  localparam int HB     = hsv2rgb_pkg::HueBits;
  localparam int FB     = hsv2rgb_pkg::FracBits;
  localparam int NW     = C + FB;
  localparam int MW     = NW - 5;
  localparam int PW     = NW + MW;
  localparam int YW     = 2 * C;
  localparam int OutW   = ((3 * C + 7) / 8) * 8;
  localparam int NS     = 9;
  localparam int DivM   = (2 ** NW) / hsv2rgb_pkg::HueSector;

  localparam logic [C-1:0]  Full   = C'((2 ** C) - 1);
  localparam logic [NW-1:0] FullD  = NW'(((2 ** C) - 1) * hsv2rgb_pkg::HueSector);
  localparam logic [PW-1:0] RecipM = PW'(DivM);
  localparam logic [NW-1:0] Sec60  = NW'(hsv2rgb_pkg::HueSector);
  localparam logic [HB-1:0] Turn   = HB'(hsv2rgb_pkg::HueTurn);
  localparam logic [HB-1:0] Hs     = HB'(hsv2rgb_pkg::HueSector);

  // Handshake and valid bits.
  logic [NS-1:0] en;
  logic [NS-1:0] valid_d, valid_q;

  always_comb begin
    en[NS-1] = ~valid_q[NS-1] | m_axis_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = ~valid_q[i] | en[i+1];
    end
  end

  always_comb begin
    valid_d[0] = en[0] ? s_axis_tvalid : valid_q[0];
    for (int i = 1; i < NS; i++) begin
      valid_d[i] = en[i] ? valid_q[i-1] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[NS-1];

  // Stage 1: hue wrap, sector and offset within the sector.
  logic [HB-1:0] in_hue, hue_w;
  logic [C-1:0]  in_sat, in_val;
  logic [2:0]    sec_num;
  logic [HB-1:0] sec_base;

  assign in_hue = s_axis_tdata[HB-1:0];
  assign in_sat = s_axis_tdata[HB +: C];
  assign in_val = s_axis_tdata[HB + C +: C];

  always_comb begin
    hue_w    = (in_hue >= Turn) ? in_hue - Turn : in_hue;
    sec_num  = 3'(hue_w >= Hs) + 3'(hue_w >= 2 * Hs) + 3'(hue_w >= 3 * Hs)
             + 3'(hue_w >= 4 * Hs) + 3'(hue_w >= 5 * Hs);
    sec_base = HB'(sec_num) * Hs;
  end

  hsv2rgb_pkg::sector_e s1_sec_q;
  logic [FB-1:0]        s1_frac_q;
  logic [C-1:0]         s1_sat_q, s1_val_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_sec_q  <= hsv2rgb_pkg::sector_e'(sec_num);
      s1_frac_q <= FB'(hue_w - sec_base);
      s1_sat_q  <= in_sat;
      s1_val_q  <= in_val;
    end
  end

  // Stage 2: numerators of p, q and t.
  logic [NW-1:0] s_frac, s_cofrac;

  assign s_frac   = NW'(s1_sat_q) * NW'(s1_frac_q);
  assign s_cofrac = NW'(s1_sat_q) * (Sec60 - NW'(s1_frac_q));

  hsv2rgb_pkg::sector_e s2_sec_q;
  logic [NW-1:0]        s2_nq_q, s2_nt_q;
  logic [C-1:0]         s2_ns_q, s2_val_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_sec_q <= s1_sec_q;
      s2_nq_q  <= FullD - s_frac;
      s2_nt_q  <= FullD - s_cofrac;
      s2_ns_q  <= Full - s1_sat_q;
      s2_val_q <= s1_val_q;
    end
  end

  // Stage 3: numerator divided by 60, reciprocal estimate.
  logic [PW-1:0] nq_prod, nt_prod;

  assign nq_prod = PW'(s2_nq_q) * RecipM;
  assign nt_prod = PW'(s2_nt_q) * RecipM;

  hsv2rgb_pkg::sector_e s3_sec_q;
  logic [NW-1:0]        s3_nq_q, s3_nt_q;
  logic [C-1:0]         s3_eq_q, s3_et_q, s3_ns_q, s3_val_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_sec_q <= s2_sec_q;
      s3_nq_q  <= s2_nq_q;
      s3_nt_q  <= s2_nt_q;
      s3_eq_q  <= nq_prod[NW +: C];
      s3_et_q  <= nt_prod[NW +: C];
      s3_ns_q  <= s2_ns_q;
      s3_val_q <= s2_val_q;
    end
  end

  // Stage 4: correct the estimate, split numerator into quotient and remainder.
  logic [NW-1:0] rq, rt;
  logic          fix_q, fix_t;

  always_comb begin
    rq    = s3_nq_q - NW'(s3_eq_q) * Sec60;
    rt    = s3_nt_q - NW'(s3_et_q) * Sec60;
    fix_q = (rq >= Sec60);
    fix_t = (rt >= Sec60);
  end

  hsv2rgb_pkg::sector_e s4_sec_q;
  logic [C-1:0]         s4_q1_q, s4_t1_q, s4_ns_q, s4_val_q;
  logic [FB-1:0]        s4_q0_q, s4_t0_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_sec_q <= s3_sec_q;
      s4_q1_q  <= fix_q ? s3_eq_q + C'(1) : s3_eq_q;
      s4_t1_q  <= fix_t ? s3_et_q + C'(1) : s3_et_q;
      s4_q0_q  <= fix_q ? FB'(rq - Sec60) : FB'(rq);
      s4_t0_q  <= fix_t ? FB'(rt - Sec60) : FB'(rt);
      s4_ns_q  <= s3_ns_q;
      s4_val_q <= s3_val_q;
    end
  end

  // Stage 5: scale by brightness.
  hsv2rgb_pkg::sector_e s5_sec_q;
  logic [YW-1:0]        s5_qhi_q, s5_thi_q, s5_p_q;
  logic [NW-1:0]        s5_qlo_q, s5_tlo_q;
  logic [C-1:0]         s5_val_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_sec_q <= s4_sec_q;
      s5_qhi_q <= YW'(s4_val_q) * YW'(s4_q1_q);
      s5_thi_q <= YW'(s4_val_q) * YW'(s4_t1_q);
      s5_qlo_q <= NW'(s4_val_q) * NW'(s4_q0_q);
      s5_tlo_q <= NW'(s4_val_q) * NW'(s4_t0_q);
      s5_p_q   <= YW'(s4_val_q) * YW'(s4_ns_q);
      s5_val_q <= s4_val_q;
    end
  end

  // Stage 6: low partial products divided by 60, reciprocal estimate.
  logic [PW-1:0] lq_prod, lt_prod;

  assign lq_prod = PW'(s5_qlo_q) * RecipM;
  assign lt_prod = PW'(s5_tlo_q) * RecipM;

  hsv2rgb_pkg::sector_e s6_sec_q;
  logic [YW-1:0]        s6_qhi_q, s6_thi_q, s6_p_q;
  logic [NW-1:0]        s6_qlo_q, s6_tlo_q;
  logic [C-1:0]         s6_eq_q, s6_et_q, s6_val_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_sec_q <= s5_sec_q;
      s6_qhi_q <= s5_qhi_q;
      s6_thi_q <= s5_thi_q;
      s6_p_q   <= s5_p_q;
      s6_qlo_q <= s5_qlo_q;
      s6_tlo_q <= s5_tlo_q;
      s6_eq_q  <= lq_prod[NW +: C];
      s6_et_q  <= lt_prod[NW +: C];
      s6_val_q <= s5_val_q;
    end
  end

  // Stage 7: correct the estimate and recombine.
  logic [NW-1:0] lrq, lrt;
  logic [C-1:0]  lq, lt;

  always_comb begin
    lrq = s6_qlo_q - NW'(s6_eq_q) * Sec60;
    lrt = s6_tlo_q - NW'(s6_et_q) * Sec60;
    lq  = (lrq >= Sec60) ? s6_eq_q + C'(1) : s6_eq_q;
    lt  = (lrt >= Sec60) ? s6_et_q + C'(1) : s6_et_q;
  end

  hsv2rgb_pkg::sector_e s7_sec_q;
  logic [YW-1:0]        s7_yq_q, s7_yt_q, s7_yp_q;
  logic [C-1:0]         s7_val_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_sec_q <= s6_sec_q;
      s7_yq_q  <= s6_qhi_q + YW'(lq);
      s7_yt_q  <= s6_thi_q + YW'(lt);
      s7_yp_q  <= s6_p_q;
      s7_val_q <= s6_val_q;
    end
  end

  // Stage 8: division by full scale, estimate that is low by at most one.
  logic [YW:0] sq, st, sp;

  always_comb begin
    sq = (YW + 1)'(s7_yq_q) + (YW + 1)'(s7_yq_q >> C);
    st = (YW + 1)'(s7_yt_q) + (YW + 1)'(s7_yt_q >> C);
    sp = (YW + 1)'(s7_yp_q) + (YW + 1)'(s7_yp_q >> C);
  end

  hsv2rgb_pkg::sector_e s8_sec_q;
  logic [YW-1:0]        s8_yq_q, s8_yt_q, s8_yp_q;
  logic [C-1:0]         s8_zq_q, s8_zt_q, s8_zp_q, s8_val_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s8_sec_q <= s7_sec_q;
      s8_yq_q  <= s7_yq_q;
      s8_yt_q  <= s7_yt_q;
      s8_yp_q  <= s7_yp_q;
      s8_zq_q  <= sq[C +: C];
      s8_zt_q  <= st[C +: C];
      s8_zp_q  <= sp[C +: C];
      s8_val_q <= s7_val_q;
    end
  end

  // Stage 9: correct the quotient and route channels by sector.
  logic [YW:0]  fq, ft, fp;
  logic [C-1:0] cq, ct, cp;
  logic [C-1:0] red_d, green_d, blue_d;

  always_comb begin
    fq = (YW + 1)'(s8_yq_q) - ((YW + 1)'(s8_zq_q) << C) + (YW + 1)'(s8_zq_q);
    ft = (YW + 1)'(s8_yt_q) - ((YW + 1)'(s8_zt_q) << C) + (YW + 1)'(s8_zt_q);
    fp = (YW + 1)'(s8_yp_q) - ((YW + 1)'(s8_zp_q) << C) + (YW + 1)'(s8_zp_q);
    cq = (fq >= (YW + 1)'(Full)) ? s8_zq_q + C'(1) : s8_zq_q;
    ct = (ft >= (YW + 1)'(Full)) ? s8_zt_q + C'(1) : s8_zt_q;
    cp = (fp >= (YW + 1)'(Full)) ? s8_zp_q + C'(1) : s8_zp_q;
    case (s8_sec_q)
      hsv2rgb_pkg::SECTOR_RED_YELLOW: begin
        red_d = s8_val_q; green_d = ct; blue_d = cp;
      end
      hsv2rgb_pkg::SECTOR_YELLOW_GREEN: begin
        red_d = cq; green_d = s8_val_q; blue_d = cp;
      end
      hsv2rgb_pkg::SECTOR_GREEN_CYAN: begin
        red_d = cp; green_d = s8_val_q; blue_d = ct;
      end
      hsv2rgb_pkg::SECTOR_CYAN_BLUE: begin
        red_d = cp; green_d = cq; blue_d = s8_val_q;
      end
      hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
        red_d = ct; green_d = cp; blue_d = s8_val_q;
      end
      default: begin
        red_d = s8_val_q; green_d = cp; blue_d = cq;
      end
    endcase
  end

  logic [C-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign m_axis_tdata = OutW'({blue_q, green_q, red_q});

endmodule

`default_nettype wire

### dv/tb_hsv_to_rgb_converter.sv
// Self-checking stream testbench for the HSV to RGB converter with directed and random pixels.
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter;

  localparam int ChanBits    = hsv2rgb_pkg::ChannelBitsDefault;
  localparam int HueW        = hsv2rgb_pkg::HueBits;
  localparam int FullScale   = (1 << ChanBits) - 1;
  localparam int InWidth     = ((HueW + 2 * ChanBits + 7) / 8) * 8;
  localparam int OutWidth    = ((3 * ChanBits + 7) / 8) * 8;
  localparam int NumDirected = 22;
  localparam int PhaseItems  = 100;
  localparam int DrainCycles = 30;
  localparam int CycleLimit  = 200000;
  localparam int MaxReports  = 10;

  typedef struct packed {
    logic [ChanBits-1:0] red;
    logic [ChanBits-1:0] green;
    logic [ChanBits-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HueW-1:0]     hue;
    logic [ChanBits-1:0] sat;
    logic [ChanBits-1:0] bright;
    logic                known;
    rgb_t                rgb;
  } pixel_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InWidth-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutWidth-1:0] m_axis_tdata;

  rgb_t        rgb_expect_q[$];
  pixel_row_t  pixel_rows[NumDirected];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  hsv_to_rgb_converter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic rgb_t rgb_from_hsv(logic [HueW-1:0] hue, logic [ChanBits-1:0] sat,
                                        logic [ChanBits-1:0] bright);
    int unsigned          h, frac, span, s, v, p, q, t;
    hsv2rgb_pkg::sector_e sector;
    rgb_t                 rgb;
    h = hue;
    s = sat;
    v = bright;
    if (h >= hsv2rgb_pkg::HueTurn) begin
      h = h - hsv2rgb_pkg::HueTurn;
    end
    sector = hsv2rgb_pkg::sector_e'(h / hsv2rgb_pkg::HueSector);
    frac   = h % hsv2rgb_pkg::HueSector;
    span   = FullScale * hsv2rgb_pkg::HueSector;
    p = v * (FullScale - s) / FullScale;
    q = v * (span - s * frac) / span;
    t = v * (span - s * (hsv2rgb_pkg::HueSector - frac)) / span;
    case (sector)
      hsv2rgb_pkg::SECTOR_RED_YELLOW: begin
        rgb.red = ChanBits'(v); rgb.green = ChanBits'(t); rgb.blue = ChanBits'(p);
      end
      hsv2rgb_pkg::SECTOR_YELLOW_GREEN: begin
        rgb.red = ChanBits'(q); rgb.green = ChanBits'(v); rgb.blue = ChanBits'(p);
      end
      hsv2rgb_pkg::SECTOR_GREEN_CYAN: begin
        rgb.red = ChanBits'(p); rgb.green = ChanBits'(v); rgb.blue = ChanBits'(t);
      end
      hsv2rgb_pkg::SECTOR_CYAN_BLUE: begin
        rgb.red = ChanBits'(p); rgb.green = ChanBits'(q); rgb.blue = ChanBits'(v);
      end
      hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
        rgb.red = ChanBits'(t); rgb.green = ChanBits'(p); rgb.blue = ChanBits'(v);
      end
      default: begin
        rgb.red = ChanBits'(v); rgb.green = ChanBits'(p); rgb.blue = ChanBits'(q);
      end
    endcase
    return rgb;
  endfunction

  function automatic logic [ChanBits-1:0] pick_channel();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) begin
      return '0;
    end else if (roll == 1) begin
      return ChanBits'(FullScale);
    end
    return ChanBits'($urandom_range(FullScale));
  endfunction

  task automatic send_pixel(pixel_row_t row);
    rgb_t expect_rgb;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InWidth'({row.bright, row.sat, row.hue});
    do @(posedge clk_i); while (!s_axis_tready);
    if (row.known) begin
      expect_rgb = row.rgb;
    end else begin
      expect_rgb = rgb_from_hsv(row.hue, row.sat, row.bright);
    end
    rgb_expect_q = {rgb_expect_q, expect_rgb};
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    rgb_t seen;
    rgb_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.red   = m_axis_tdata[ChanBits-1:0];
      seen.green = m_axis_tdata[2*ChanBits-1:ChanBits];
      seen.blue  = m_axis_tdata[3*ChanBits-1:2*ChanBits];
      if (rgb_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("Unexpected item: rgb %0d %0d %0d", seen.red, seen.green, seen.blue);
        end
      end else begin
        want = rgb_expect_q.pop_front();
        if (seen.red !== want.red || seen.green !== want.green || seen.blue !== want.blue) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("Mismatch: expected rgb %0d %0d %0d, got %0d %0d %0d",
                     want.red, want.green, want.blue, seen.red, seen.green, seen.blue);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    pixel_row_t  row;
    int unsigned phase;
    pixel_rows = '{
      '{9'd0,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{9'd360, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{9'd60,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
      '{9'd120, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
      '{9'd240, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
      '{9'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{9'd511, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{9'd200, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{9'd359, 8'd0,   8'd128, 1'b1, '{8'd128, 8'd128, 8'd128}},
      '{9'd180, 8'd255, 8'd255, 1'b0, '0},
      '{9'd300, 8'd255, 8'd255, 1'b0, '0},
      '{9'd59,  8'd255, 8'd255, 1'b0, '0},
      '{9'd359, 8'd255, 8'd255, 1'b0, '0},
      '{9'd361, 8'd200, 8'd100, 1'b0, '0},
      '{9'd511, 8'd255, 8'd255, 1'b0, '0},
      '{9'd419, 8'd255, 8'd255, 1'b0, '0},
      '{9'd30,  8'd128, 8'd200, 1'b0, '0},
      '{9'd90,  8'd77,  8'd150, 1'b0, '0},
      '{9'd150, 8'd1,   8'd254, 1'b0, '0},
      '{9'd210, 8'd254, 8'd1,   1'b0, '0},
      '{9'd270, 8'd170, 8'd85,  1'b0, '0},
      '{9'd330, 8'd85,  8'd170, 1'b0, '0}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send_pixel(pixel_rows[i]);
    end

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
        default: begin src_idle_pct = 10; sink_stall_pct = 10; end
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(4) == 0) begin
          row.hue = HueW'($urandom_range((1 << HueW) - 1));
        end else begin
          row.hue = HueW'($urandom_range(hsv2rgb_pkg::HueTurn - 1));
        end
        row.sat    = pick_channel();
        row.bright = pick_channel();
        row.known  = 1'b0;
        row.rgb    = '0;
        send_pixel(row);
      end
    end

    s_axis_tvalid <= 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    while (rgb_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
